// ===== design/rbu_pkg.sv =====
package rbu_pkg;

    localparam int RECORD_MAX = 63;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;

    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // record_mode codes
    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNBLOCK = 2'd2;

    // case_mode codes
    localparam logic [MODE_W-1:0] CASE_KEEP  = 2'd0;
    localparam logic [MODE_W-1:0] CASE_LOWER = 2'd1;
    localparam logic [MODE_W-1:0] CASE_UPPER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_MODE     = 2'd2;

    typedef enum logic [1:0] {
        EMIT_SPACE,
        EMIT_BYTE,
        EMIT_NEWLINE
    } emit_kind_t;

    // what one input transaction asks of the sequencer
    typedef struct packed {
        logic lead_nz;
        logic has_x;
        logic pad_nz;
        logic has_nl;
    } plan_flags_t;

    typedef struct packed {
        plan_flags_t fresh;
        logic        lead_one;
        logic        pad_one;
        logic        x_pend;
        logic        pad_nz;
        logic        nl_pend;
        logic        out_free;
    } rbu_status_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic       dec_lead;
        logic       dec_pad;
    } rbu_cmd_t;

    function automatic logic [BYTE_W-1:0] apply_case(
        input logic [BYTE_W-1:0] b,
        input logic [MODE_W-1:0] cmode
    );
        logic [BYTE_W-1:0] r;
        r = b;
        if (cmode == CASE_LOWER && b >= 8'h41 && b <= 8'h5A)
            r = b + 8'h20;
        else if (cmode == CASE_UPPER && b >= 8'h61 && b <= 8'h7A)
            r = b - 8'h20;
        return r;
    endfunction

endpackage

// ===== design/rbu_if.sv =====
interface rbu_in_if;
    logic                          valid;
    logic                          ready;
    logic [rbu_pkg::BYTE_W-1:0]    in_byte;
    logic                          end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface rbu_out_if;
    logic                          valid;
    logic                          ready;
    logic [rbu_pkg::BYTE_W-1:0]    out_byte;
    logic                          last_of_run;
    logic                          stream_done;
    logic [rbu_pkg::COUNT_W-1:0]   truncated_records;

    modport source (output valid, output out_byte, output last_of_run,
                    output stream_done, output truncated_records, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input stream_done, input truncated_records, output ready);
endinterface

// ===== design/rbu_datapath.sv =====
module rbu_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rbu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rbu_pkg::BYTE_W-1:0]       in_byte,
    input  logic                             end_of_stream,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [rbu_pkg::BYTE_W-1:0]       out_byte,
    output logic                             last_of_run,
    output logic                             stream_done,
    output logic [rbu_pkg::COUNT_W-1:0]      truncated_records,
    input  rbu_pkg::rbu_cmd_t                cmd,
    output rbu_pkg::rbu_status_t             status
);

    logic [rbu_pkg::MODE_W-1:0]  record_mode_reg;
    logic [rbu_pkg::LEN_W-1:0]   record_length_reg;
    logic [rbu_pkg::MODE_W-1:0]  case_mode_reg;

    logic [rbu_pkg::LEN_W-1:0]   column_reg, column_next;
    logic [rbu_pkg::LEN_W-1:0]   pending_reg, pending_next;
    logic                        overflow_reg, overflow_next;
    logic [rbu_pkg::COUNT_W-1:0] trunc_reg;

    logic [rbu_pkg::LEN_W-1:0]   lead_reg;
    logic [rbu_pkg::LEN_W-1:0]   pad_reg;
    logic                        x_pend_reg;
    logic [rbu_pkg::BYTE_W-1:0]  x_byte_reg;
    logic                        nl_pend_reg;
    logic                        eos_reg;

    logic                        out_valid_reg;
    logic [rbu_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;
    logic [rbu_pkg::COUNT_W-1:0] out_trunc_reg;

    logic [rbu_pkg::LEN_W-1:0]   len_eff;
    logic [rbu_pkg::LEN_W:0]     len_wide;
    logic [rbu_pkg::BYTE_W-1:0]  cased;
    logic [rbu_pkg::LEN_W:0]     col_inc;
    logic [rbu_pkg::LEN_W-1:0]   fin_col;
    logic                        fin_ovf;
    logic                        finish;
    logic                        trunc_bump;

    logic [rbu_pkg::LEN_W-1:0]   p_lead;
    logic [rbu_pkg::LEN_W-1:0]   p_pad;
    logic                        p_x;
    logic [rbu_pkg::BYTE_W-1:0]  p_x_byte;
    logic                        p_nl;

    always_comb
    begin
        if (record_length_reg == '0)
            len_eff = rbu_pkg::LEN_W'(1);
        else if (record_length_reg > rbu_pkg::LEN_W'(rbu_pkg::RECORD_MAX))
            len_eff = rbu_pkg::LEN_W'(rbu_pkg::RECORD_MAX);
        else
            len_eff = record_length_reg;
    end

    assign len_wide = {1'b0, len_eff};
    assign cased    = rbu_pkg::apply_case(in_byte, case_mode_reg);
    assign col_inc  = {1'b0, column_reg} + 1'b1;

    // plan the results of the byte at the input and the state it leaves
    always_comb
    begin
        p_lead        = '0;
        p_pad         = '0;
        p_x           = 1'b0;
        p_x_byte      = cased;
        p_nl          = 1'b0;
        column_next   = column_reg;
        pending_next  = pending_reg;
        overflow_next = overflow_reg;
        fin_col       = column_reg;
        fin_ovf       = overflow_reg;
        finish        = 1'b0;
        trunc_bump    = 1'b0;

        case (record_mode_reg)
            rbu_pkg::MODE_BLOCK:
            begin
                p_x_byte = in_byte;
                if (in_byte == rbu_pkg::NEWLINE_BYTE)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    if (column_reg < len_eff)
                    begin
                        p_x     = 1'b1;
                        fin_col = column_reg + 1'b1;
                    end
                    else
                    begin
                        fin_ovf = 1'b1;
                    end
                    finish        = end_of_stream;
                    column_next   = fin_col;
                    overflow_next = fin_ovf;
                end
                if (finish)
                begin
                    if (fin_ovf)
                        trunc_bump = 1'b1;
                    else if (fin_col < len_eff)
                        p_pad = len_eff - fin_col;
                    column_next   = '0;
                    overflow_next = 1'b0;
                end
            end
            rbu_pkg::MODE_UNBLOCK:
            begin
                if (cased == rbu_pkg::SPACE_BYTE)
                begin
                    // hold the space back until a non-space shows it is not trailing
                    if (col_inc < len_wide)
                        pending_next = pending_reg + 1'b1;
                end
                else
                begin
                    p_lead       = pending_reg;
                    p_x          = 1'b1;
                    pending_next = '0;
                end
                column_next = col_inc[rbu_pkg::LEN_W-1:0];
                if (col_inc >= len_wide || end_of_stream)
                begin
                    // a run holds at most 64 results: drop the newline past that
                    p_nl         = !(p_x && p_lead == '1);
                    column_next  = '0;
                    pending_next = '0;
                end
            end
            default:
            begin
                p_x = 1'b1;
            end
        endcase

        if (end_of_stream)
        begin
            column_next   = '0;
            pending_next  = '0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_mode_reg   <= rbu_pkg::MODE_PASS;
            record_length_reg <= rbu_pkg::LEN_W'(rbu_pkg::RECORD_MAX);
            case_mode_reg     <= rbu_pkg::CASE_KEEP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rbu_pkg::REG_RECORD_MODE:
                    record_mode_reg <= cfg_data[rbu_pkg::MODE_W-1:0];
                rbu_pkg::REG_RECORD_LENGTH:
                    record_length_reg <= cfg_data[rbu_pkg::LEN_W-1:0];
                rbu_pkg::REG_CASE_MODE:
                    case_mode_reg <= cfg_data[rbu_pkg::MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            pending_reg  <= '0;
            overflow_reg <= 1'b0;
            trunc_reg    <= '0;
        end
        else if (cmd.load)
        begin
            column_reg   <= column_next;
            pending_reg  <= pending_next;
            overflow_reg <= overflow_next;
            if (trunc_bump && trunc_reg != '1)
                trunc_reg <= trunc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= '0;
            pad_reg     <= '0;
            x_pend_reg  <= 1'b0;
            nl_pend_reg <= 1'b0;
            eos_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            lead_reg    <= p_lead;
            pad_reg     <= p_pad;
            x_pend_reg  <= p_x;
            nl_pend_reg <= p_nl;
            eos_reg     <= end_of_stream;
        end
        else
        begin
            if (cmd.dec_lead)
                lead_reg <= lead_reg - 1'b1;
            if (cmd.dec_pad)
                pad_reg <= pad_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_byte_reg <= p_x_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.kind)
                rbu_pkg::EMIT_BYTE:    out_byte_reg <= x_byte_reg;
                rbu_pkg::EMIT_NEWLINE: out_byte_reg <= rbu_pkg::NEWLINE_BYTE;
                default:               out_byte_reg <= rbu_pkg::SPACE_BYTE;
            endcase
            out_last_reg  <= cmd.last;
            out_done_reg  <= eos_reg;
            out_trunc_reg <= trunc_reg;
        end
    end

    assign status.fresh.lead_nz = (p_lead != '0);
    assign status.fresh.has_x   = p_x;
    assign status.fresh.pad_nz  = (p_pad != '0);
    assign status.fresh.has_nl  = p_nl;
    assign status.lead_one      = (lead_reg == rbu_pkg::LEN_W'(1));
    assign status.pad_one       = (pad_reg == rbu_pkg::LEN_W'(1));
    assign status.x_pend        = x_pend_reg;
    assign status.pad_nz        = (pad_reg != '0);
    assign status.nl_pend       = nl_pend_reg;
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign last_of_run       = out_last_reg;
    assign stream_done       = out_done_reg;
    assign truncated_records = out_trunc_reg;

endmodule

// ===== design/rbu_controller.sv =====
module rbu_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rbu_pkg::rbu_status_t  status,
    output rbu_pkg::rbu_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_MAIN,
        ST_PAD,
        ST_NEWLINE
    } state_t;

    state_t state_reg, state_next;

    function automatic state_t first_phase(
        input logic lead_nz,
        input logic has_x,
        input logic pad_nz,
        input logic has_nl
    );
        state_t s;
        if (lead_nz)
            s = ST_LEAD;
        else if (has_x)
            s = ST_MAIN;
        else if (pad_nz)
            s = ST_PAD;
        else if (has_nl)
            s = ST_NEWLINE;
        else
            s = ST_IDLE;
        return s;
    endfunction

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = rbu_pkg::EMIT_SPACE;
        state_next = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LEAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.dec_lead = 1'b1;
                    cmd.last     = status.lead_one && !status.x_pend
                                   && !status.pad_nz && !status.nl_pend;
                    if (status.lead_one)
                        state_next = first_phase(1'b0, status.x_pend,
                                                 status.pad_nz, status.nl_pend);
                end
            end
            ST_MAIN:
            begin
                cmd.kind = rbu_pkg::EMIT_BYTE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = !status.pad_nz && !status.nl_pend;
                    state_next = first_phase(1'b0, 1'b0, status.pad_nz, status.nl_pend);
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.dec_pad = 1'b1;
                    cmd.last    = status.pad_one && !status.nl_pend;
                    if (status.pad_one)
                        state_next = first_phase(1'b0, 1'b0, 1'b0, status.nl_pend);
                end
            end
            ST_NEWLINE:
            begin
                cmd.kind = rbu_pkg::EMIT_NEWLINE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // take the next byte as the final result of this one leaves
        in_ready = (state_reg == ST_IDLE) || (cmd.emit && cmd.last);
        cmd.load = in_valid && in_ready;
        if (cmd.load)
            state_next = first_phase(status.fresh.lead_nz, status.fresh.has_x,
                                     status.fresh.pad_nz, status.fresh.has_nl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/record_block_unblock_converter.sv =====
// Channel   Role     Payload
// -------   ------   ---------------------------------------------------------
// feed      sink     in_byte[7:0], end_of_stream
// result    source   out_byte[7:0], last_of_run, stream_done, truncated_records[31:0]
// cfg_*     write    cfg_wr_en, cfg_index[1:0], cfg_data[5:0]
//
// The sequencer drives one result byte a cycle into the output register, and
// takes the next input byte as the last result of this one leaves. Pass mode
// runs at one byte per cycle; padding spaces in block mode and held spaces plus
// the newline in unblock mode go out before the next byte is taken. A stalled
// result holds the sequencer. Reset is asynchronous and active low; it restores
// the registers to pass mode, length 63, case unchanged, clears the truncation count.
module record_block_unblock_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rbu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbu_pkg::CFG_DATA_W-1:0]  cfg_data,
    rbu_in_if.sink                          feed,
    rbu_out_if.source                       result
);

    rbu_pkg::rbu_cmd_t    cmd;
    rbu_pkg::rbu_status_t status;
    logic                 in_ready;

    rbu_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (feed.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rbu_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_byte           (feed.in_byte),
        .end_of_stream     (feed.end_of_stream),
        .out_ready         (result.ready),
        .out_valid         (result.valid),
        .out_byte          (result.out_byte),
        .last_of_run       (result.last_of_run),
        .stream_done       (result.stream_done),
        .truncated_records (result.truncated_records),
        .cmd               (cmd),
        .status            (status)
    );

    assign feed.ready = in_ready;

endmodule

// ===== design/rbu_checker.sv =====
module rbu_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           last_of_run,
    input  logic                           stream_done,
    input  logic [rbu_pkg::COUNT_W-1:0]    truncated_records
);

    logic                        out_acc;
    logic                        seen_reg;
    logic                        mid_run_reg;
    logic                        done_reg;
    logic [rbu_pkg::COUNT_W-1:0] trunc_reg;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            mid_run_reg <= 1'b0;
            done_reg    <= 1'b0;
            trunc_reg   <= '0;
        end
        else if (out_acc)
        begin
            seen_reg    <= 1'b1;
            mid_run_reg <= !last_of_run;
            done_reg    <= stream_done;
            trunc_reg   <= truncated_records;
        end
    end

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // all results of one input share its stream flag and count
    a_run_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && mid_run_reg |->
            stream_done == done_reg && truncated_records == trunc_reg)
        else $error("result fields changed inside one run");

    // the truncation count never goes down
    a_trunc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg |-> truncated_records >= trunc_reg)
        else $error("truncation count decreased");

    // nothing is offered once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered during reset");

endmodule

bind record_block_unblock_converter rbu_checker u_rbu_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .last_of_run       (result.last_of_run),
    .stream_done       (result.stream_done),
    .truncated_records (result.truncated_records)
);

// ===== dv/record_block_unblock_converter_tb.sv =====
module record_block_unblock_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbu_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [MODE_W-1:0] CASE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               last_of_run;
        logic               stream_done;
        logic [COUNT_W-1:0] truncated_records;
    } out_rec_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbu_in_if  feed_if();
    rbu_out_if result_if();

    record_block_unblock_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feed      (feed_if),
        .result    (result_if)
    );

    // converter state as the stream sees it
    logic [MODE_W-1:0]  cur_mode;
    logic [LEN_W-1:0]   cur_len;
    logic [MODE_W-1:0]  cur_case;
    logic [LEN_W-1:0]   line_col;
    logic [LEN_W-1:0]   held_spaces;
    logic               line_cut;
    logic [COUNT_W-1:0] cut_lines;

    logic [BYTE_W-1:0] staged_bytes [$];
    out_rec_t          expected_outputs [$];

    int mismatches;
    int bytes_sent;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        if (cur_case == CASE_LOWER && b >= "A" && b <= "Z")
            return b + 8'h20;
        if (cur_case == CASE_UPPER && b >= "a" && b <= "z")
            return b - 8'h20;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(9) < 6)
            return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic close_block_line(input int len);
        if (line_cut)
        begin
            if (cut_lines != '1)
                cut_lines++;
        end
        else
        begin
            while (line_col < len)
            begin
                staged_bytes.push_back(SPACE_BYTE);
                line_col++;
            end
        end
        line_col = '0;
        line_cut = 1'b0;
    endtask

    task automatic convert_byte(input logic [BYTE_W-1:0] in_b, input logic eos);
        int len;
        int col_next;
        int n;
        logic [BYTE_W-1:0] b;
        out_rec_t r;
        len = (cur_len == 0) ? 1 : int'(cur_len);
        staged_bytes.delete();
        if (cur_mode == MODE_BLOCK)
        begin
            if (in_b == NEWLINE_BYTE)
            begin
                close_block_line(len);
            end
            else
            begin
                if (line_col < len)
                begin
                    staged_bytes.push_back(in_b);
                    line_col++;
                end
                else
                begin
                    line_cut = 1'b1;
                end
                if (eos)
                    close_block_line(len);
            end
        end
        else if (cur_mode == MODE_UNBLOCK)
        begin
            b = fold_case(in_b);
            col_next = int'(line_col) + 1;
            if (b == SPACE_BYTE)
            begin
                if (col_next < len)
                    held_spaces++;
            end
            else
            begin
                repeat (held_spaces) staged_bytes.push_back(SPACE_BYTE);
                held_spaces = '0;
                staged_bytes.push_back(b);
            end
            // record is full or the stream ends: close it, held spaces drop
            if (col_next >= len || eos)
            begin
                staged_bytes.push_back(NEWLINE_BYTE);
                col_next = 0;
                held_spaces = '0;
            end
            line_col = col_next[LEN_W-1:0];
        end
        else
        begin
            staged_bytes.push_back(fold_case(in_b));
        end
        if (eos)
        begin
            line_col = '0;
            held_spaces = '0;
            line_cut = 1'b0;
        end
        n = (staged_bytes.size() > 64) ? 64 : staged_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            r.out_byte = staged_bytes[k];
            r.last_of_run = (k == n - 1);
            r.stream_done = eos;
            r.truncated_records = cut_lines;
            expected_outputs.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            feed_if.valid <= 1'b0;
            @(posedge clk);
        end
        feed_if.valid <= 1'b1;
        feed_if.in_byte <= b;
        feed_if.end_of_stream <= eos;
        @(posedge clk);
        while (!feed_if.ready) @(posedge clk);
        convert_byte(b, eos);
        bytes_sent++;
    endtask

    // write all three registers once the converter has gone quiet
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                             input logic [MODE_W-1:0] cmode);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{REG_RECORD_MODE, REG_RECORD_LENGTH, REG_CASE_MODE};
        vals = '{{4'b0, mode}, len, {4'b0, cmode}};
        feed_if.valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            if (regs[i] == REG_RECORD_MODE)
                cur_mode = vals[i][MODE_W-1:0];
            else if (regs[i] == REG_RECORD_LENGTH)
                cur_len = vals[i];
            else
                cur_case = vals[i][MODE_W-1:0];
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 64;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 64;
            end
            default:
            begin
                send_idle_pct = 34;
                recv_stall_pct = 34;
            end
        endcase
    endtask

    task automatic test_pass_mode();
        set_idling(0);
        configure(MODE_PASS, 6'd63, CASE_UPPER);
        send_byte(8'h61, 1'b0);
        send_byte(8'h7B, 1'b0);
        configure(MODE_PASS, 6'd1, CASE_LOWER);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_block_mode();
        set_idling(1);
        // case folding must not touch block mode
        configure(MODE_BLOCK, 6'd2, CASE_UPPER);
        send_byte("a", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte("d", 1'b0);
        send_byte("e", 1'b0);
        send_byte("f", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte("g", 1'b1);
    endtask

    task automatic test_unblock_mode();
        set_idling(2);
        configure(MODE_UNBLOCK, 6'd4, CASE_LOWER);
        send_byte("A", 1'b0);
        send_byte(SPACE_BYTE, 1'b0);
        send_byte(SPACE_BYTE, 1'b0);
        send_byte("B", 1'b0);
        send_byte("x", 1'b0);
        send_byte(SPACE_BYTE, 1'b1);
    endtask

    task automatic test_special_cases();
        set_idling(3);
        // zero length behaves as one
        configure(MODE_UNBLOCK, 6'd0, CASE_KEEP);
        send_byte("a", 1'b0);
        send_byte(SPACE_BYTE, 1'b0);
        configure(MODE_SPARE, 6'd5, CASE_SPARE);
        send_byte("a", 1'b0);
        send_byte("Q", 1'b1);
        // shrink the record under a half-built line
        configure(MODE_BLOCK, 6'd4, CASE_KEEP);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        configure(MODE_BLOCK, 6'd2, CASE_KEEP);
        send_byte("d", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        configure(MODE_BLOCK, 6'd63, CASE_KEEP);
        send_byte(NEWLINE_BYTE, 1'b0);
    endtask

    task automatic test_random_streams();
        int base;
        int phase_base;
        int phase;
        int sel;
        int eff;
        int rlen;
        int shape;
        int pattern;
        int split;
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] b;
        base = bytes_sent;
        phase = 0;
        while (bytes_sent - base < 190)
        begin
            set_idling(phase);
            sel = $urandom_range(9);
            mode = (sel == 0) ? MODE_PASS : (sel == 1) ? MODE_SPARE :
                   (sel < 6) ? MODE_BLOCK : MODE_UNBLOCK;
            sel = $urandom_range(9);
            len = (sel == 0) ? 6'd63 : (sel == 1) ? 6'd0 :
                  (sel == 2) ? 6'($urandom_range(9, 62)) : 6'($urandom_range(1, 8));
            configure(mode, len, 2'($urandom_range(3)));
            eff = (len == 0) ? 1 : int'(len);
            phase_base = bytes_sent;
            while (bytes_sent - phase_base < 28)
            begin
                if (mode == MODE_BLOCK)
                begin
                    rlen = $urandom_range(0, eff + 2);
                    shape = $urandom_range(11);
                    if (shape == 2)
                    begin
                        // raw noise, newlines included
                        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
                    end
                    else
                    begin
                        for (int j = 0; j < rlen; j++)
                        begin
                            b = text_byte();
                            if (b == NEWLINE_BYTE)
                                b = SPACE_BYTE;
                            send_byte(b, shape == 0 && j == rlen - 1);
                        end
                        // shape 0 ends the stream, shape 1 leaves the line open
                        if (shape == 0 && rlen == 0)
                            send_byte(text_byte(), 1'b1);
                        else if (shape >= 3)
                            send_byte(NEWLINE_BYTE, 1'b0);
                    end
                end
                else if (mode == MODE_UNBLOCK)
                begin
                    shape = $urandom_range(9);
                    rlen = (shape == 0) ? $urandom_range(1, eff) : eff;
                    pattern = $urandom_range(2);
                    split = $urandom_range(0, rlen);
                    for (int j = 0; j < rlen; j++)
                    begin
                        if (pattern == 0)
                            b = $urandom_range(1) ? SPACE_BYTE : text_byte();
                        else if (pattern == 1)
                            b = (j < split) ? text_byte() : SPACE_BYTE;
                        else
                            b = (j < rlen - 1) ? SPACE_BYTE : text_byte();
                        send_byte(b, shape == 0 && j == rlen - 1);
                    end
                end
                else
                begin
                    repeat (8)
                    begin
                        b = ($urandom_range(9) < 3) ? 8'($urandom_range(255)) : text_byte();
                        send_byte(b, $urandom_range(11) == 0);
                    end
                end
            end
            phase++;
        end
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_rec_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                $display("%0t: out_byte expected none actual %0h", $time, result_if.out_byte);
            end
            else
            begin
                want = expected_outputs.pop_front();
                check_field("out_byte", COUNT_W'(want.out_byte),
                            COUNT_W'(result_if.out_byte));
                check_field("last_of_run", COUNT_W'(want.last_of_run),
                            COUNT_W'(result_if.last_of_run));
                check_field("stream_done", COUNT_W'(want.stream_done),
                            COUNT_W'(result_if.stream_done));
                check_field("truncated_records", want.truncated_records,
                            result_if.truncated_records);
            end
        end
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        feed_if.valid = 1'b0;
        feed_if.in_byte = '0;
        feed_if.end_of_stream = 1'b0;
        result_if.ready = 1'b0;
        cur_mode = MODE_PASS;
        cur_len = 6'd63;
        cur_case = CASE_KEEP;
        line_col = '0;
        held_spaces = '0;
        line_cut = 1'b0;
        cut_lines = '0;
        mismatches = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_mode();
        test_block_mode();
        test_unblock_mode();
        test_special_cases();
        test_random_streams();
        feed_if.valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== record_block_unblock_converter.f =====
design/rbu_pkg.sv
design/rbu_if.sv
design/rbu_datapath.sv
design/rbu_controller.sv
design/record_block_unblock_converter.sv
design/rbu_checker.sv
dv/record_block_unblock_converter_tb.sv
